// File: design/lag_pkg.sv
`timescale 1ns / 1ps
package lag_pkg;

  localparam int P_W      = 48;  // result width
  localparam int X_W      = 24;  // coordinate width
  localparam int DEG_W    = 4;
  localparam int ORD_W    = 6;
  localparam int ALPHA_W  = 6;   // |order| is at most 32
  localparam int C_W      = 6;   // k - 1 + alpha is at most 62
  localparam int INT_W    = 7;   // 2k - 1 + alpha is at most 93
  localparam int CH_W     = P_W / 2;
  localparam int DIV_STEP = 4;   // quotient bits per divider cycle

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DRAIN,
    ST_DIVS,
    ST_DIVW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;    // clear accumulator
    logic en;     // issue one partial product
    logic term;   // 0: a * L_{k-1}, 1: c * L_{k-2}
    logic chunk;  // which half of the L operand
  } mac_ctrl_t;

endpackage

// File: design/lag_if.sv
`timescale 1ns / 1ps
interface lag_in_if;
  import lag_pkg::*;
  logic                    valid;
  logic                    ready;
  logic        [X_W-1:0]   x_value;
  logic        [DEG_W-1:0] degree;
  logic signed [ORD_W-1:0] order;

  modport source (output valid, x_value, degree, order, input ready);
  modport sink   (input valid, x_value, degree, order, output ready);
endinterface

interface lag_out_if;
  import lag_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [P_W-1:0] poly_value;
  logic                  overflow;

  modport source (output valid, poly_value, overflow, input ready);
  modport sink   (input valid, poly_value, overflow, output ready);
endinterface

// File: design/lag_mac.sv
`timescale 1ns / 1ps
module lag_mac #(
  parameter int AM_W      = 24,
  parameter int NUM_W     = 74,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lag_pkg::mac_ctrl_t            ctrl,
  input  logic [AM_W-1:0]               a_mag,
  input  logic                          a_neg,
  input  logic signed [lag_pkg::P_W-1:0] p1,
  input  logic signed [lag_pkg::P_W-1:0] p2,
  input  logic [lag_pkg::C_W-1:0]       coef,
  output logic signed [NUM_W-1:0]       acc
);
  import lag_pkg::*;

  localparam int PR_W = AM_W + CH_W;

  logic signed [P_W-1:0] psel;
  logic                  pneg;
  logic [P_W-1:0]        pmag;
  logic [AM_W-1:0]       mul_a;
  logic [CH_W-1:0]       mul_b;
  logic                  sub;
  logic [PR_W-1:0]       prod_r;
  logic                  sub_r;
  logic                  vld_r;
  logic [1:0]            sh_r;
  logic [NUM_W-1:0]      addend;
  logic signed [NUM_W-1:0] acc_r;

  always_comb begin
    psel  = ctrl.term ? p2 : p1;
    pneg  = psel[P_W-1];
    pmag  = pneg ? P_W'(-psel) : P_W'(psel);
    mul_a = ctrl.term ? AM_W'(coef) : a_mag;
    mul_b = ctrl.chunk ? pmag[P_W-1:CH_W] : pmag[CH_W-1:0];
    // second term is subtracted, so its sign flips
    sub   = ctrl.term ? ~pneg : (a_neg ^ pneg);
  end

  always_ff @(posedge clk) begin
    prod_r <= PR_W'(mul_a * mul_b);
    sub_r  <= sub;
    sh_r   <= {ctrl.term, ctrl.chunk};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctrl.en;
    end
  end

  always_comb begin
    case (sh_r)
      2'b00:   addend = NUM_W'(prod_r);
      2'b01:   addend = NUM_W'(prod_r) << CH_W;
      2'b10:   addend = NUM_W'(prod_r) << FRAC_BITS;
      default: addend = NUM_W'(prod_r) << (FRAC_BITS + CH_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (vld_r) begin
      acc_r <= sub_r ? acc_r - $signed(addend) : acc_r + $signed(addend);
    end
  end

  assign acc = acc_r;

endmodule

// File: design/lag_div.sv
`timescale 1ns / 1ps
module lag_div #(
  parameter int NUM_W     = 74,
  parameter int FRAC_BITS = 16,
  parameter int KW        = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [NUM_W-1:0]        num,
  input  logic [KW-1:0]                  divisor,
  output logic                           done,
  output logic signed [lag_pkg::P_W-1:0] quo,
  output logic                           sat
);
  import lag_pkg::*;

  localparam int QW  = NUM_W - FRAC_BITS;
  localparam int QP  = ((QW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int NIT = QP / DIV_STEP;
  localparam int CW  = $clog2(NIT + 1);
  localparam int RW  = KW + 1;

  logic                 busy_r;
  logic                 fin_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [QP-1:0]        q_r;
  logic [KW-1:0]        r_r;
  logic [FRAC_BITS-1:0] lo_r;
  logic                 neg_r;
  logic signed [P_W-1:0] quo_r;
  logic                 sat_r;

  logic [NUM_W-1:0]     mag;
  logic [QP-1:0]        q_it;
  logic [KW-1:0]        r_it;
  logic                 rnd;
  logic [QP:0]          qr;
  logic [QP:0]          lim;
  logic [QP:0]          qs;
  logic                 over;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // long division by a small integer, DIV_STEP quotient bits per cycle
  always_comb begin
    logic [RW-1:0] tr;
    logic [KW-1:0] rr;
    logic [QP-1:0] qq;
    rr = r_r;
    qq = q_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      tr = {rr, qq[QP-1]};
      qq = {qq[QP-2:0], 1'b0};
      if (tr >= RW'(divisor)) begin
        rr    = KW'(tr - RW'(divisor));
        qq[0] = 1'b1;
      end else begin
        rr = KW'(tr);
      end
    end
    q_it = qq;
    r_it = rr;
  end

  // round half away from zero on the full remainder, then clamp
  always_comb begin
    rnd  = {r_r, lo_r, 1'b0} >= {1'b0, divisor, {FRAC_BITS{1'b0}}};
    qr   = (QP+1)'(q_r) + (QP+1)'(rnd);
    lim  = (QP+1)'({1'b0, {(P_W-1){1'b1}}}) + (QP+1)'(neg_r);
    over = qr > lim;
    qs   = over ? lim : qr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= QP'(mag >> FRAC_BITS);
      lo_r  <= mag[FRAC_BITS-1:0];
      r_r   <= '0;
      neg_r <= num[NUM_W-1];
      cnt_r <= CW'(NIT);
    end else if (busy_r) begin
      q_r   <= q_it;
      r_r   <= r_it;
      cnt_r <= cnt_r - CW'(1);
    end
    if (fin_r) begin
      quo_r <= neg_r ? -$signed(qs[P_W-1:0]) : $signed(qs[P_W-1:0]);
      sat_r <= over;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

endmodule

// File: design/associated_laguerre_eval.sv
`timescale 1ns / 1ps
// Degree 0 or 1 gives its result in the cycle after the word is taken; degree n >= 2 runs one
// recurrence step for each k from 2 to n. Each step passes through setup, the shared
// partial-product multiplier (its a operand is AM_W = max(FRAC_BITS+7, 24) bits wide), drain,
// divider start and the divider (4 bits/cycle).
// One item at a time: the next word is taken the cycle after the result is taken.
// Synchronous active-low reset idles the sequencer; no clearing pass is needed.
module associated_laguerre_eval #(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lag_in_if.sink    in_ch,
  lag_out_if.source out_ch
);
  import lag_pkg::*;

  localparam int KW    = $clog2(MAX_DEGREE + 1);
  localparam int AM_W  = ((FRAC_BITS + INT_W) > X_W) ? (FRAC_BITS + INT_W) : X_W;
  localparam int A_W   = AM_W + 1;
  localparam int NUM_W = AM_W + 50;

  state_t state_r, state_nxt;
  logic [X_W-1:0]     x_r, x_nxt;
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [KW-1:0]      deg_r, deg_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic signed [P_W-1:0] p1_r, p1_nxt;
  logic signed [P_W-1:0] p2_r, p2_nxt;
  logic               ovf_r, ovf_nxt;
  logic [AM_W-1:0]    a_mag_r, a_mag_nxt;
  logic               a_neg_r, a_neg_nxt;
  logic [C_W-1:0]     coef_r, coef_nxt;
  logic [1:0]         cnt_r, cnt_nxt;

  logic [ALPHA_W-1:0] alpha_in;
  logic [KW-1:0]      deg_in;
  logic [P_W-1:0]     one_fx;
  logic [P_W-1:0]     p1_init;
  logic [INT_W-1:0]   int_v;
  logic [A_W-1:0]     a_full;

  mac_ctrl_t               mac_ctrl;
  logic signed [NUM_W-1:0] acc;
  logic                    div_start;
  logic                    div_done;
  logic signed [P_W-1:0]   div_quo;
  logic                    div_sat;

  always_comb begin
    alpha_in = in_ch.order[ORD_W-1]
             ? ALPHA_W'(-$signed({in_ch.order[ORD_W-1], in_ch.order}))
             : ALPHA_W'(in_ch.order);
    deg_in   = (in_ch.degree > MAX_DEGREE) ? KW'(MAX_DEGREE) : KW'(in_ch.degree);
    one_fx   = P_W'(1) << FRAC_BITS;
    p1_init  = ((P_W'(alpha_in) + P_W'(1)) << FRAC_BITS) - P_W'(in_ch.x_value);
    int_v    = INT_W'({k_r, 1'b0}) + INT_W'(alpha_r) - INT_W'(1);
    a_full   = (A_W'(int_v) << FRAC_BITS) - A_W'(x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    alpha_r <= alpha_nxt;
    deg_r   <= deg_nxt;
    k_r     <= k_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    ovf_r   <= ovf_nxt;
    a_mag_r <= a_mag_nxt;
    a_neg_r <= a_neg_nxt;
    coef_r  <= coef_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    alpha_nxt = alpha_r;
    deg_nxt   = deg_r;
    k_nxt     = k_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    ovf_nxt   = ovf_r;
    a_mag_nxt = a_mag_r;
    a_neg_nxt = a_neg_r;
    coef_nxt  = coef_r;
    cnt_nxt   = cnt_r;
    mac_ctrl  = '0;
    div_start = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          x_nxt     = in_ch.x_value;
          alpha_nxt = alpha_in;
          deg_nxt   = deg_in;
          k_nxt     = KW'(2);
          ovf_nxt   = 1'b0;
          p2_nxt    = $signed(one_fx);
          p1_nxt    = (deg_in == '0) ? $signed(one_fx) : $signed(p1_init);
          state_nxt = (deg_in < KW'(2)) ? ST_OUT : ST_PREP;
        end
      end
      ST_PREP: begin
        // register the step's coefficients ahead of the multiplier
        a_neg_nxt    = a_full[A_W-1];
        a_mag_nxt    = a_full[A_W-1] ? AM_W'(-a_full) : AM_W'(a_full);
        coef_nxt     = C_W'(k_r) + C_W'(alpha_r) - C_W'(1);
        mac_ctrl.clr = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.term  = cnt_r[1];
        mac_ctrl.chunk = cnt_r[0];
        cnt_nxt        = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          p2_nxt  = p1_r;
          p1_nxt  = div_quo;
          ovf_nxt = ovf_r | div_sat;
          if (k_r == deg_r) begin
            state_nxt = ST_OUT;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = ST_PREP;
          end
        end
      end
      ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.poly_value = p1_r;
  assign out_ch.overflow   = ovf_r;

  lag_mac #(
    .AM_W      (AM_W),
    .NUM_W     (NUM_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .a_mag (a_mag_r),
    .a_neg (a_neg_r),
    .p1    (p1_r),
    .p2    (p2_r),
    .coef  (coef_r),
    .acc   (acc)
  );

  lag_div #(
    .NUM_W     (NUM_W),
    .FRAC_BITS (FRAC_BITS),
    .KW        (KW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num     (acc),
    .divisor (k_r),
    .done    (div_done),
    .quo     (div_quo),
    .sat     (div_sat)
  );

endmodule

// File: design/lag_chk.sv
`timescale 1ns / 1ps
module lag_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [lag_pkg::DEG_W-1:0]     in_degree,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lag_pkg::P_W-1:0]       out_poly_value,
  input logic                          out_overflow
);
  import lag_pkg::*;

  localparam logic [P_W-1:0] ONE_FX = P_W'(1) << FRAC_BITS;

  // one item in flight: never ready while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after taking a word");

  a_degree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_degree == '0)
    |=> out_valid && (out_poly_value == ONE_FX) && !out_overflow)
    else $error("degree zero did not give 1.0 on the next cycle");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
    |=> out_valid && $stable(out_poly_value) && $stable(out_overflow))
    else $error("stalled result word changed");

  a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid && in_ready)
    else $error("block not idle after result taken");

endmodule

bind associated_laguerre_eval lag_chk #(
  .FRAC_BITS (FRAC_BITS)
) u_lag_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_degree      (in_ch.degree),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_poly_value (out_ch.poly_value),
  .out_overflow   (out_ch.overflow)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lag_pkg::*;

  localparam int     MAX_DEG   = 15;
  localparam int     FRAC      = 16;
  localparam longint ONE_FX    = longint'(1) << FRAC;
  localparam int     N_RANDOM  = 1900;
  localparam int     DRAIN_CYC = 400;

  typedef struct {
    logic [P_W-1:0] val;
    logic           ovf;
  } poly_result_t;

  typedef struct {
    logic [X_W-1:0]   x;
    logic [DEG_W-1:0] deg;
    logic [ORD_W-1:0] ord;
    bit               typed;
    logic [P_W-1:0]   val;
    logic             ovf;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lag_in_if  in_ch ();
  lag_out_if out_ch ();

  associated_laguerre_eval #(
    .MAX_DEGREE(MAX_DEG),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  poly_result_t pending_poly[$];
  stim_row_t    directed_rows[$];
  int           mismatches;
  int           words_sent;
  int           results_seen;
  int           saturated_seen;
  bit           no_stall;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("associated_laguerre_eval: mismatch");
    $finish;
  end

  // L_n^|m|(x) by the three-term recurrence, exact in 128 bits, rounded division by k
  function automatic poly_result_t laguerre_fx(logic [X_W-1:0] xv, logic [DEG_W-1:0] dg,
                                               logic [ORD_W-1:0] od);
    longint              xs;
    longint              alpha;
    int                  n;
    int                  k;
    logic signed [127:0] l1, l2, a_t, c_t, num, mag, quo, rmd, dv, lim;
    logic                neg;
    poly_result_t        r;
    xs    = {40'd0, xv};
    alpha = od[ORD_W-1] ? 64 - od : od;
    n     = dg;
    if (n > MAX_DEG) n = MAX_DEG;
    r.ovf = 1'b0;
    if (n == 0) begin
      r.val = P_W'(ONE_FX);
    end else begin
      // first degree cannot leave the 48-bit range with a 24-bit x
      l2 = ONE_FX;
      l1 = ONE_FX * (1 + alpha) - xs;
      for (k = 2; k <= n; k++) begin
        a_t = (2 * k - 1 + alpha) * ONE_FX - xs;
        c_t = k - 1 + alpha;
        num = a_t * l1 - c_t * l2 * ONE_FX;
        neg = num[127];
        mag = neg ? -num : num;
        dv  = k * ONE_FX;
        quo = mag / dv;
        rmd = mag % dv;
        if (rmd * 2 >= dv) quo = quo + 1;
        lim = neg ? (128'sd1 <<< (P_W - 1)) : (128'sd1 <<< (P_W - 1)) - 1;
        if (quo > lim) begin
          quo   = lim;
          r.ovf = 1'b1;
        end
        l2 = l1;
        l1 = neg ? -quo : quo;
      end
      r.val = l1[P_W-1:0];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_word(stim_row_t row);
    int           gap;
    poly_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.x_value <= row.x;
    in_ch.degree  <= row.deg;
    in_ch.order   <= row.ord;
    do @(posedge clk); while (!in_ch.ready);
    if (row.typed) begin
      res.val = row.val;
      res.ovf = row.ovf;
    end else begin
      res = laguerre_fx(row.x, row.deg, row.ord);
    end
    pending_poly.push_back(res);
    words_sent++;
  endtask

  task automatic wait_drained();
    while (pending_poly.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.overflow) saturated_seen++;
      if (pending_poly.size() == 0) begin
        $error("result word with nothing outstanding: poly_value %0d overflow %0b",
               $signed(out_ch.poly_value), out_ch.overflow);
        mismatches++;
      end else begin
        want = pending_poly.pop_front();
        if (out_ch.poly_value !== want.val) begin
          $error("poly_value: expected %0d, got %0d", $signed(want.val),
                 $signed(out_ch.poly_value));
          mismatches++;
        end
        if (out_ch.overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, out_ch.overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int        sel;
    mismatches     = 0;
    words_sent     = 0;
    results_seen   = 0;
    saturated_seen = 0;
    no_stall       = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.x_value <= '0;
    in_ch.degree  <= '0;
    in_ch.order   <= '0;

    // x, degree, order, typed, value, overflow
    directed_rows.push_back('{24'h000000, 4'd0,  6'd0,    1'b1, 48'd65536, 1'b0});
    directed_rows.push_back('{24'hFFFFFF, 4'd0,  -6'sd32, 1'b1, 48'd65536, 1'b0});
    directed_rows.push_back('{24'h000000, 4'd1,  6'd0,    1'b1, 48'd65536, 1'b0});
    directed_rows.push_back('{24'h000000, 4'd1,  -6'sd32, 1'b1, 48'd2162688, 1'b0});
    directed_rows.push_back('{24'h000000, 4'd1,  6'sd31,  1'b1, 48'd2097152, 1'b0});
    directed_rows.push_back('{24'hFFFFFF, 4'd1,  6'd0,    1'b1, -48'sd16711679, 1'b0});
    directed_rows.push_back('{24'h010000, 4'd1,  -6'sd1,  1'b1, 48'd65536, 1'b0});
    directed_rows.push_back('{24'h000000, 4'd2,  6'd0,    1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h000000, 4'd15, 6'd0,    1'b0, '0, 1'b0});
    directed_rows.push_back('{24'hFFFFFF, 4'd15, 6'd0,    1'b0, '0, 1'b0});
    directed_rows.push_back('{24'hFFFFFF, 4'd15, -6'sd32, 1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h000000, 4'd15, -6'sd32, 1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h000001, 4'd15, 6'sd31,  1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h800000, 4'd7,  -6'sd31, 1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h030000, 4'd3,  6'sd5,   1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h0A0000, 4'd15, 6'd0,    1'b0, '0, 1'b0});
    directed_rows.push_back('{24'hFFFFFF, 4'd2,  6'sd31,  1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h123456, 4'd14, -6'sd7,  1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h400000, 4'd8,  6'sd1,   1'b0, '0, 1'b0});
    directed_rows.push_back('{24'h020000, 4'd10, 6'sd2,   1'b0, '0, 1'b0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      no_stall = (i >= 600 && i < 800);
      // hold the sender until every outstanding result is back
      if (i == 300 || i == 1300) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      sel = $urandom_range(0, 9);
      if (sel < 4) row.x = X_W'($urandom_range(0, 20 * 65536));
      else if (sel < 7) row.x = X_W'($urandom());
      else if (sel < 8) begin
        case ($urandom_range(0, 3))
          0:       row.x = '0;
          1:       row.x = 24'h000001;
          2:       row.x = 24'h010000;
          default: row.x = '1;
        endcase
      end else row.x = X_W'($urandom_range(0, 65535));
      row.deg   = DEG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 15));
      row.ord   = ORD_W'($urandom_range(0, 63));
      row.typed = 1'b0;
      row.val   = '0;
      row.ovf   = 1'b0;
      send_word(row);
    end
    no_stall     = 1'b0;
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("%0d words evaluated, %0d results checked, %0d of them saturated",
             words_sent, results_seen, saturated_seen);
    $display("degrees 0 to 15, orders -32 to 31, x from zero to full scale");
    if (mismatches == 0 && pending_poly.size() == 0) begin
      $display("associated_laguerre_eval: match");
    end else begin
      $display("associated_laguerre_eval: mismatch");
    end
    $finish;
  end

endmodule
